// ===== design/mmqf_pkg.sv =====
// Shared types, constants and helpers for the masked quadratic-form block.
package mmqf_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int FRAC_BITS      = 16;
  localparam int VALUE_W        = 32;
  localparam int OUT_W          = 64;
  localparam int ACTIVE_W       = 5;
  localparam int TERM_W         = 3 * VALUE_W;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [OUT_W-1:0]   OUT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0]   OUT_MIN   = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MATRIX  = 2'd0,
    OP_NOMINAL = 2'd1,
    OP_MASK    = 2'd2,
    OP_SAMPLE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic [3:0]                 row;
    logic [3:0]                 col;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quad_form;
    logic                    saturated;
  } out_word_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic     wr_matrix;
    logic     wr_nominal;
    logic     wr_mask;
    logic     wr_sample;
    logic     load_feed;
    in_word_t word;
  } cmd_t;

  // Control part of a token that travels down the chain, one token per matrix row.
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

  // Width of the exact sum of all d_i * M_ij * d_j terms.
  function automatic int acc_width(input int max_params);
    return TERM_W + 2 * $clog2(max_params);
  endfunction

endpackage

// ===== design/masked_mahalanobis_quadratic_form.sv =====
// Top level of the masked quadratic form d^T * Cinv * d over a chain of parameter cells.
//
//   channel  | handshake                    | word
//   ---------+------------------------------+-------------------------------------
//   input    | start, busy (taken: !busy)   | in_word  (operation, row, col, value)
//   result   | out_strobe, one cycle        | out_word (quad_form, saturated)
//   config   | cfg_valid, cfg_ready         | cfg_data (active_params)
//
// Loads and non-final sample elements are taken without raising busy; busy stays low.
// The element that completes a vector of n keeps busy high while its n row tokens enter the
// chain one per cycle and pass through every cell, each cell being five registers deep.
// The result word is shown for one cycle on out_strobe, as busy falls; the receiver
// cannot stall it. cfg_ready is low while busy. Reset clears nominals, sets every mask bit
// and sets active_params to 16; matrix entries stay undefined until loaded.
module masked_mahalanobis_quadratic_form #(
  parameter  int MAX_PARAMS = mmqf_pkg::MAX_PARAMS_DEF,
  localparam int IDX_W      = $clog2(MAX_PARAMS),
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1),
  localparam int ACC_W      = mmqf_pkg::acc_width(MAX_PARAMS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mmqf_pkg::in_word_t                in_word,
  output logic                              out_strobe,
  output mmqf_pkg::out_word_t               out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmqf_pkg::ACTIVE_W-1:0]     cfg_data
);

  localparam int VW = mmqf_pkg::VALUE_W;
  localparam int OW = mmqf_pkg::OUT_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_INJECT = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           busy_r, busy_nxt;
  logic [mmqf_pkg::ACTIVE_W-1:0]  active_r;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           sat_r, sat_nxt;
  logic [IDX_W-1:0]               inj_r, inj_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic                           out_strobe_r, out_strobe_nxt;
  mmqf_pkg::out_word_t            out_word_r, out_word_nxt;

  logic                    accept;
  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]        cnt_plus;
  logic                    done;
  logic                    inj_valid;
  logic                    inj_last;
  logic                    load_feed;
  logic                    sat_any;
  logic signed [ACC_W-1:0] acc_sh;
  logic [ACC_W-OW:0]       acc_top;
  logic                    fits;
  mmqf_pkg::cmd_t          cmd;

  logic [MAX_PARAMS-1:0]   sat_hits;
  logic signed [VW-1:0]    feed_w    [MAX_PARAMS+1];
  mmqf_pkg::tok_ctl_t      tok_ctl_w [MAX_PARAMS+1];
  logic [IDX_W-1:0]        tok_row_w [MAX_PARAMS+1];
  logic signed [VW-1:0]    tok_d_w   [MAX_PARAMS+1];
  logic signed [ACC_W-1:0] tok_sum_w [MAX_PARAMS+1];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // An active count of zero acts as one; a count above the cell count is clamped.
  always_comb begin
    if (active_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(active_r) > MAX_PARAMS) begin
      n_eff = CNT_W'(MAX_PARAMS);
    end else begin
      n_eff = CNT_W'(active_r);
    end
  end

  assign cnt_plus = cnt_r + CNT_W'(1);
  assign done     = cnt_plus >= n_eff;
  assign inj_last = (CNT_W'(inj_r) + CNT_W'(1)) == n_eff;
  assign sat_any  = |sat_hits;

  assign cmd.wr_matrix  = accept && (in_word.operation == mmqf_pkg::OP_MATRIX);
  assign cmd.wr_nominal = accept && (in_word.operation == mmqf_pkg::OP_NOMINAL);
  assign cmd.wr_mask    = accept && (in_word.operation == mmqf_pkg::OP_MASK);
  assign cmd.wr_sample  = accept && (in_word.operation == mmqf_pkg::OP_SAMPLE);
  assign cmd.load_feed  = load_feed;
  assign cmd.word       = in_word;

  // Drop 2*FRAC_BITS fraction bits with floor, then clamp to the 64-bit result.
  assign acc_sh  = acc_r >>> (2 * mmqf_pkg::FRAC_BITS);
  assign acc_top = acc_sh[ACC_W-1:OW-1];
  assign fits    = (&acc_top) || !(|acc_top);

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    cnt_nxt        = cnt_r;
    sat_nxt        = sat_r;
    inj_nxt        = inj_r;
    acc_nxt        = acc_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    load_feed      = 1'b0;
    inj_valid      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd.wr_sample) begin
          sat_nxt = sat_r || sat_any;
          if (done) begin
            cnt_nxt   = '0;
            busy_nxt  = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_plus;
          end
        end
      end
      ST_LOAD: begin
        load_feed = 1'b1;
        inj_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_INJECT;
      end
      ST_INJECT: begin
        inj_valid = 1'b1;
        inj_nxt   = inj_r + IDX_W'(1);
        if (inj_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DRAIN;
      end
      ST_EMIT: begin
        out_strobe_nxt         = 1'b1;
        out_word_nxt.quad_form = fits ? acc_sh[OW-1:0]
                               : (acc_sh[ACC_W-1] ? mmqf_pkg::OUT_MIN : mmqf_pkg::OUT_MAX);
        out_word_nxt.saturated = sat_r || !fits;
        sat_nxt                = 1'b0;
        busy_nxt               = 1'b0;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Row sums leave the end of the chain one per cycle; the last one closes the vector.
    if (tok_ctl_w[MAX_PARAMS].valid) begin
      acc_nxt = acc_r + tok_sum_w[MAX_PARAMS];
      if (tok_ctl_w[MAX_PARAMS].last) begin
        state_nxt = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      active_r     <= mmqf_pkg::ACTIVE_RST;
      cnt_r        <= '0;
      sat_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      cnt_r        <= cnt_nxt;
      sat_r        <= sat_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    inj_r      <= inj_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Row tokens enter at cell 0; the differences shift toward cell 0 to feed them.
  assign tok_ctl_w[0].valid = inj_valid;
  assign tok_ctl_w[0].last  = inj_last;
  assign tok_row_w[0]       = inj_r;
  assign tok_d_w[0]         = feed_w[0];
  assign tok_sum_w[0]       = '0;
  assign feed_w[MAX_PARAMS] = '0;

  for (genvar g = 0; g < MAX_PARAMS; g++) begin : g_cell
    mmqf_cell #(
      .MAX_PARAMS (MAX_PARAMS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .sample_idx  (cnt_r[IDX_W-1:0]),
      .n_eff       (n_eff),
      .sat_hit     (sat_hits[g]),
      .feed_in     (feed_w[g+1]),
      .feed_out    (feed_w[g]),
      .tok_ctl_in  (tok_ctl_w[g]),
      .tok_row_in  (tok_row_w[g]),
      .tok_d_in    (tok_d_w[g]),
      .tok_sum_in  (tok_sum_w[g]),
      .tok_ctl_out (tok_ctl_w[g+1]),
      .tok_row_out (tok_row_w[g+1]),
      .tok_d_out   (tok_d_w[g+1]),
      .tok_sum_out (tok_sum_w[g+1])
    );
  end

endmodule

// ===== design/mmqf_cell.sv =====
// One chain cell: nominal, mask bit and difference of one parameter plus one matrix column.
module mmqf_cell #(
  parameter  int MAX_PARAMS = mmqf_pkg::MAX_PARAMS_DEF,
  parameter  int CELL_IDX   = 0,
  localparam int IDX_W      = $clog2(MAX_PARAMS),
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1),
  localparam int ACC_W      = mmqf_pkg::acc_width(MAX_PARAMS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmqf_pkg::cmd_t                      cmd,
  input  logic [IDX_W-1:0]                    sample_idx,
  input  logic [CNT_W-1:0]                    n_eff,
  output logic                                sat_hit,
  input  logic signed [mmqf_pkg::VALUE_W-1:0] feed_in,
  output logic signed [mmqf_pkg::VALUE_W-1:0] feed_out,
  input  mmqf_pkg::tok_ctl_t                  tok_ctl_in,
  input  logic [IDX_W-1:0]                    tok_row_in,
  input  logic signed [mmqf_pkg::VALUE_W-1:0] tok_d_in,
  input  logic signed [ACC_W-1:0]             tok_sum_in,
  output mmqf_pkg::tok_ctl_t                  tok_ctl_out,
  output logic [IDX_W-1:0]                    tok_row_out,
  output logic signed [mmqf_pkg::VALUE_W-1:0] tok_d_out,
  output logic signed [ACC_W-1:0]             tok_sum_out
);

  localparam int VW = mmqf_pkg::VALUE_W;

  logic              row_ok;
  logic              row_hit;
  logic              col_hit;
  logic [IDX_W+3:0]  row_ext;
  logic              in_use;
  logic              sel;
  logic              ovf;
  logic signed [VW:0]   diff_full;
  logic signed [VW-1:0] diff_sat;
  logic signed [VW-1:0] d_nxt;
  logic signed [VW-1:0] m_gated;

  logic signed [VW-1:0] col_mem [MAX_PARAMS];
  logic signed [VW-1:0] mem_q_r;
  logic signed [VW-1:0] nominal_r;
  logic                 mask_r;
  logic signed [VW-1:0] d_r;
  logic signed [VW-1:0] feed_r;

  // Token pipeline: read, first product, split second product, term, accumulate.
  mmqf_pkg::tok_ctl_t   ctl0_r, ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [IDX_W-1:0]     row0_r, row1_r, row2_r, row3_r, row4_r;
  logic signed [VW-1:0] td0_r, td1_r, td2_r, td3_r, td4_r;
  logic signed [ACC_W-1:0] sum0_r, sum1_r, sum2_r, sum3_r, sum4_r;
  logic signed [2*VW-1:0]  p1_r;
  logic signed [2*VW:0]    lo2_r;
  logic signed [2*VW-1:0]  hi2_r;
  logic signed [ACC_W-1:0] term3_r;

  assign row_ok  = int'(cmd.word.row) < MAX_PARAMS;
  assign row_hit = int'(cmd.word.row) == CELL_IDX;
  assign col_hit = int'(cmd.word.col) == CELL_IDX;
  assign row_ext = (IDX_W + 4)'(cmd.word.row);
  assign in_use  = CELL_IDX < int'(n_eff);
  assign sel     = cmd.wr_sample && (sample_idx == IDX_W'(CELL_IDX));

  assign diff_full = {cmd.word.value[VW-1], cmd.word.value} - {nominal_r[VW-1], nominal_r};
  assign ovf       = diff_full[VW] ^ diff_full[VW-1];
  assign diff_sat  = ovf ? (diff_full[VW] ? mmqf_pkg::VALUE_MIN : mmqf_pkg::VALUE_MAX)
                         : diff_full[VW-1:0];
  assign d_nxt     = mask_r ? diff_sat : '0;
  assign sat_hit   = sel && ovf;

  // A zero difference on either side kills the term, so unused entries never matter.
  assign m_gated = (in_use && (d_r != '0) && (td0_r != '0)) ? mem_q_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.wr_matrix && col_hit && row_ok) begin
      col_mem[row_ext[IDX_W-1:0]] <= cmd.word.value;
    end
    mem_q_r <= col_mem[tok_row_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= '0;
      mask_r    <= 1'b1;
    end else begin
      if (cmd.wr_nominal && row_hit) begin
        nominal_r <= cmd.word.value;
      end
      if (cmd.wr_mask && row_hit) begin
        mask_r <= cmd.word.value[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      d_r <= d_nxt;
    end
    feed_r <= cmd.load_feed ? d_r : feed_in;
  end

  assign feed_out = feed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl0_r <= tok_ctl_in;
      ctl1_r <= ctl0_r;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    row0_r <= tok_row_in;
    td0_r  <= tok_d_in;
    sum0_r <= tok_sum_in;

    row1_r <= row0_r;
    td1_r  <= td0_r;
    sum1_r <= sum0_r;
    p1_r   <= (2*VW)'(td0_r) * (2*VW)'(m_gated);

    row2_r <= row1_r;
    td2_r  <= td1_r;
    sum2_r <= sum1_r;
    lo2_r  <= (2*VW+1)'($signed({1'b0, p1_r[VW-1:0]})) * (2*VW+1)'(d_r);
    hi2_r  <= (2*VW)'($signed(p1_r[2*VW-1:VW])) * (2*VW)'(d_r);

    row3_r  <= row2_r;
    td3_r   <= td2_r;
    sum3_r  <= sum2_r;
    term3_r <= (ACC_W'(hi2_r) <<< VW) + ACC_W'(lo2_r);

    row4_r <= row3_r;
    td4_r  <= td3_r;
    sum4_r <= sum3_r + term3_r;
  end

  assign tok_ctl_out = ctl4_r;
  assign tok_row_out = row4_r;
  assign tok_d_out   = td4_r;
  assign tok_sum_out = sum4_r;

endmodule
